// File: src/twes_pkg.sv
// shared types and constants for the two-wheel encoder speed block
// no dependencies; imported by every module of the block
`default_nettype none

package twes_pkg;

  localparam int unsigned ARC_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SPEED_W  = 24;
  localparam int unsigned FRAC_W   = 8;

  // dividend is arc_um scaled by 256, one quotient bit per step
  localparam int unsigned DIVD_W    = ARC_W + FRAC_W;
  localparam int unsigned DIV_STEPS = DIVD_W;

  localparam logic [ARC_W-1:0] ARC_RESET = 16'd1281;

  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic              wheel_side;
    logic [TIME_W-1:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_left;
    logic [COUNT_W-1:0] count_right;
    logic [SPEED_W-1:0] speed_left;
    logic [SPEED_W-1:0] speed_right;
  } out_t;

endpackage

`default_nettype wire

// File: src/twes_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on twes_pkg for field widths and the step count
`default_nettype none

module twes_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [twes_pkg::DIVD_W-1:0]  dividend,
  input  wire logic [twes_pkg::TIME_W-1:0]  divisor,
  output logic                              done,
  output logic [twes_pkg::DIVD_W-1:0]       quotient
);
  import twes_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

  // remainder never exceeds the dividend, so it never needs more than DIVD_W bits
  logic [DIVD_W-1:0]  acc_r;
  logic [DIVD_W-1:0]  rem_r;
  logic [TIME_W-1:0]  den_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DIVD_W:0]    rem_sh;
  logic               ge;
  logic [DIVD_W:0]    rem_sub;
  logic [DIVD_W-1:0]  rem_nxt;
  logic [DIVD_W-1:0]  acc_nxt;

  always_comb begin
    rem_sh  = {rem_r, acc_r[DIVD_W-1]};
    ge      = {{(TIME_W-DIVD_W-1){1'b0}}, rem_sh} >= den_r;
    rem_sub = rem_sh - den_r[DIVD_W:0];
    rem_nxt = ge ? rem_sub[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
    acc_nxt = {acc_r[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulse after the last step
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        acc_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
        cnt_r  <= CNT_W'(DIV_STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = acc_r;

endmodule

`default_nettype wire

// File: src/two_wheel_encoder_speed.sv
// top level of the two-wheel encoder speed block: wheel state, control, output register
// depends on twes_pkg and twes_div
`default_nettype none

// Takes one transfer at a time on the input channel: an encoder edge for the left or
// right wheel with a millisecond timestamp, or a request to clear both edge counts.
// Every transfer produces exactly one result with both edge counts and both speeds.
// Speed is floor(arc_um * 256 / dt) in 1/256 mm/s, where dt is the time since that
// wheel's previous edge (or the timestamp itself on the wheel's first edge); a zero
// gap gives 16777215. An edge runs the 24-step bit-serial divider, its quotient goes
// into that wheel's speed register, then the result is registered; a clear skips the
// divider. in_stall is high from the accepting edge until the result has been loaded
// into the output register, which then waits for out_stall on its own while the next
// input transfer is taken. arc_um resets to 1281; the user must write it through
// cfg_we/cfg_wdata only while the block is idle, which the block does not enforce.

module two_wheel_encoder_speed (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [twes_pkg::ARC_W-1:0]   cfg_wdata,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire twes_pkg::in_t                in_data,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output twes_pkg::out_t                    out_data
);
  import twes_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t             state_r;
  logic [ARC_W-1:0]   arc_r;

  // per-wheel state, index 0 left, 1 right
  logic [COUNT_W-1:0] count_r [2];
  logic [TIME_W-1:0]  last_r  [2];
  logic [1:0]         seen_r;
  logic [SPEED_W-1:0] speed_r [2];
  logic               side_r;

  out_t               out_r;
  logic               out_valid_r;

  logic               in_xfer;
  logic               edge_xfer;
  logic               out_free;
  logic [TIME_W-1:0]  dt_nxt;
  logic               div_done;
  logic [DIVD_W-1:0]  div_q;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign edge_xfer = in_xfer && (in_data.req_type == REQ_EDGE);
  // output register can take a new result this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // gap since the wheel's previous edge, wraps modulo 2^32; first edge uses the stamp
  always_comb begin
    if (seen_r[in_data.wheel_side]) begin
      dt_nxt = in_data.time_ms - last_r[in_data.wheel_side];
    end else begin
      dt_nxt = in_data.time_ms;
    end
  end

  // a zero divisor makes every step subtract nothing, so the quotient comes out
  // all ones, which is exactly the saturated speed
  twes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (edge_xfer),
    .dividend ({arc_r, {FRAC_W{1'b0}}}),
    .divisor  (dt_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      arc_r       <= ARC_RESET;
      count_r[0]  <= '0;
      count_r[1]  <= '0;
      last_r[0]   <= '0;
      last_r[1]   <= '0;
      seen_r      <= '0;
      speed_r[0]  <= '0;
      speed_r[1]  <= '0;
      side_r      <= SIDE_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        arc_r <= cfg_wdata;
      end

      // result enters from ST_FIN, leaves when the far side takes it
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_data.req_type == REQ_CLEAR) begin
              // clear touches the counts only
              count_r[0] <= '0;
              count_r[1] <= '0;
              state_r    <= ST_FIN;
            end else begin
              count_r[in_data.wheel_side] <= count_r[in_data.wheel_side] + 1'b1;
              last_r[in_data.wheel_side]  <= in_data.time_ms;
              seen_r[in_data.wheel_side]  <= 1'b1;
              side_r                      <= in_data.wheel_side;
              state_r                     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            speed_r[side_r] <= div_q[SPEED_W-1:0];
            state_r         <= ST_FIN;
          end
        end
        ST_FIN: begin
          // snapshot both wheels once the output register is free
          if (out_free) begin
            out_r.count_left  <= count_r[0];
            out_r.count_right <= count_r[1];
            out_r.speed_left  <= speed_r[0];
            out_r.speed_right <= speed_r[1];
            state_r           <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: src/twes_chk.sv
// port-level checker for the two-wheel encoder speed block, bound to the top level
// depends on twes_pkg and two_wheel_encoder_speed
`default_nettype none

module twes_chk (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_stall,
  input  wire twes_pkg::in_t   in_data,
  input  wire logic            out_valid,
  input  wire logic            out_stall,
  input  wire twes_pkg::out_t  out_data
);
  import twes_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: an input transfer closes the input side next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // an edge needs the divider, so no new result can show right after it is taken
  a_edge_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_EDGE) && !out_valid
    |=> !out_valid)
    else $error("edge result appeared without divider latency");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind two_wheel_encoder_speed twes_chk u_twes_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
